>>> design/tapc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapc_pkg
// shared constants, types and saturation helper of the two-axis pid core
// ----------------------------------------------------------------------------
package tapc_pkg;

    localparam int AXES      = 2;
    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = 48;

    localparam logic [1:0] CFG_GAIN_PROP  = 2'd0;
    localparam logic [1:0] CFG_GAIN_INTEG = 2'd1;
    localparam logic [1:0] CFG_GAIN_DERIV = 2'd2;

    // datapath operations, one per controller step
    localparam logic [3:0] OP_LOAD    = 4'd0;  // latch inputs, form error
    localparam logic [3:0] OP_INC     = 4'd1;  // multiply error by step
    localparam logic [3:0] OP_ACC     = 4'd2;  // update integral, form diff
    localparam logic [3:0] OP_DIVINIT = 4'd3;  // start divider
    localparam logic [3:0] OP_DIVSTEP = 4'd4;  // one quotient bit
    localparam logic [3:0] OP_DIVEND  = 4'd5;  // sign and saturate quotient
    localparam logic [3:0] OP_MULP    = 4'd6;
    localparam logic [3:0] OP_MULI    = 4'd7;
    localparam logic [3:0] OP_MULD    = 4'd8;
    localparam logic [3:0] OP_SUM     = 4'd9;  // final sums, store drive
    localparam logic [3:0] OP_NONE    = 4'd10;

    typedef struct packed {
        logic       en;
        logic [3:0] op;
        logic       axis;
    } tapc_cmd_t;

    typedef struct packed {
        logic div_last;
    } tapc_status_t;

    function automatic logic [32:0] sat_wide(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647)
            r = {1'b1, 32'h7fffffff};
        else if (v < -66'sd2147483648)
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/tapc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapc_datapath
// shared multiplier, restoring divider, axis state and result register
// ----------------------------------------------------------------------------
module tapc_datapath (
    input  wire                    clk,
    input  wire                    rst_n,
    input  tapc_pkg::tapc_cmd_t    cmd,
    output tapc_pkg::tapc_status_t status,
    input  wire                    cfg_we,
    input  wire [1:0]              cfg_index,
    input  wire [31:0]             cfg_data,
    input  wire [31:0]             target_x,
    input  wire [31:0]             target_y,
    input  wire [31:0]             measured_x,
    input  wire [31:0]             measured_y,
    input  wire [31:0]             time_step,
    output logic [31:0]            drive_x,
    output logic [31:0]            drive_y,
    output logic                   clipped,
    output logic                   zero_step
);
    import tapc_pkg::*;

    logic signed [31:0] gp_reg, gi_reg, gd_reg;
    logic signed [31:0] acc_reg [AXES];
    logic signed [31:0] prev_reg [AXES];
    logic signed [31:0] tgt_reg [AXES];
    logic signed [31:0] mea_reg [AXES];
    logic [31:0]        step_reg;
    logic signed [31:0] err_reg, diff_reg, der_reg, pt_reg, it_reg, dt_reg;
    logic               clip_reg;
    logic [47:0]        quo_reg;
    logic [32:0]        rem_reg;
    logic [47:0]        num_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [65:0] prod_sh;
    logic [32:0]        rem_try;
    logic signed [48:0] quo_signed;
    logic               ax;
    logic [32:0]        err_sat, mul_sat, acc_sum, diff_sat, quo_sat;
    logic signed [65:0] sum1_w;
    logic [32:0]        s1, s2;
    logic [31:0]        dx_reg, dy_reg;
    logic               clipo_reg, zo_reg, clipx_reg;

    assign ax = (AXES > 1) ? cmd.axis : 1'b0;
    assign status.div_last = (cnt_reg == 6'(DIV_STEPS - 1));

    // one shared multiplier, operands picked by the operation
    always_comb
    begin
        case (cmd.op)
            OP_INC:  begin mul_a = err_reg; mul_b = $signed(step_reg); end
            OP_MULP: begin mul_a = gp_reg;  mul_b = err_reg; end
            OP_MULI: begin mul_a = gi_reg;  mul_b = acc_reg[ax]; end
            default: begin mul_a = gd_reg;  mul_b = der_reg; end
        endcase
    end

    always_comb
    begin
        logic signed [64:0] p65;
        if (cmd.op == OP_INC)
            p65 = $signed({{33{mul_a[31]}}, mul_a}) * $signed({33'd0, step_reg});
        else
            p65 = 65'(mul_a * mul_b);
        prod_sh = 66'(p65 >>> FRAC_BITS);
    end

    // x error comes straight from the ports, y error from the latched copy
    assign err_sat  = ax ? sat_wide(66'(tgt_reg[AXES-1]) - 66'(mea_reg[AXES-1]))
                         : sat_wide(66'($signed(target_x)) - 66'($signed(measured_x)));
    assign mul_sat  = sat_wide(prod_sh);
    assign acc_sum  = sat_wide(66'(acc_reg[ax]) + 66'(pt_reg));
    assign diff_sat = sat_wide(66'(err_reg) - 66'(prev_reg[ax]));
    assign quo_sat  = sat_wide(66'(quo_signed));

    assign rem_try    = {rem_reg[31:0], num_reg[47]} - {1'b0, step_reg};
    assign quo_signed = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_reg <= '0;
            gi_reg <= '0;
            gd_reg <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                acc_reg[i]  <= '0;
                prev_reg[i] <= '0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GAIN_PROP:  gp_reg <= cfg_data;
                    CFG_GAIN_INTEG: gi_reg <= cfg_data;
                    CFG_GAIN_DERIV: gd_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.en)
            begin
                case (cmd.op)
                    OP_ACC:
                    begin
                        acc_reg[ax]  <= $signed(acc_sum[31:0]);
                        prev_reg[ax] <= err_reg;
                    end
                    OP_DIVINIT: cnt_reg <= '0;
                    OP_DIVSTEP: cnt_reg <= cnt_reg + 6'd1;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    if (ax == 1'b0)
                    begin
                        tgt_reg[0] <= target_x;
                        mea_reg[0] <= measured_x;
                        if (AXES > 1)
                        begin
                            tgt_reg[AXES-1] <= target_y;
                            mea_reg[AXES-1] <= measured_y;
                        end
                        step_reg <= time_step;
                    end
                    err_reg  <= err_sat[31:0];
                    clip_reg <= err_sat[32];
                end
                OP_INC:
                begin
                    // increment reuses pt_reg as scratch
                    pt_reg   <= mul_sat[31:0];
                    clip_reg <= clip_reg | mul_sat[32];
                end
                OP_ACC:
                begin
                    if (step_reg != 32'd0)
                    begin
                        diff_reg <= diff_sat[31:0];
                        clip_reg <= clip_reg | acc_sum[32] | diff_sat[32];
                    end
                    else
                    begin
                        diff_reg <= '0;
                        clip_reg <= clip_reg | acc_sum[32];
                    end
                end
                OP_DIVINIT:
                begin
                    neg_reg <= diff_reg[31];
                    num_reg <= {(diff_reg[31] ? 32'(-diff_reg) : 32'(diff_reg)), 16'd0};
                    rem_reg <= '0;
                    quo_reg <= '0;
                end
                OP_DIVSTEP:
                begin
                    if (!rem_try[32])
                        rem_reg <= rem_try;
                    else
                        rem_reg <= {rem_reg[31:0], num_reg[47]};
                    quo_reg <= {quo_reg[46:0], ~rem_try[32]};
                    num_reg <= {num_reg[46:0], 1'b0};
                end
                OP_DIVEND:
                begin
                    if (step_reg == 32'd0)
                        der_reg <= '0;
                    else
                    begin
                        der_reg  <= quo_sat[31:0];
                        clip_reg <= clip_reg | quo_sat[32];
                    end
                end
                OP_MULP:
                begin
                    pt_reg   <= mul_sat[31:0];
                    clip_reg <= clip_reg | mul_sat[32];
                end
                OP_MULI:
                begin
                    it_reg   <= mul_sat[31:0];
                    clip_reg <= clip_reg | mul_sat[32];
                end
                OP_MULD:
                begin
                    dt_reg   <= mul_sat[31:0];
                    clip_reg <= clip_reg | mul_sat[32];
                end
                default: ;
            endcase
        end
    end

    // final two sums of the drive
    assign s1     = sat_wide(66'(pt_reg) + 66'(it_reg));
    assign sum1_w = 66'($signed(s1[31:0]));
    assign s2     = sat_wide(sum1_w + 66'(dt_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.en && cmd.op == OP_SUM)
        begin
            if (ax == 1'b0)
            begin
                dx_reg    <= s2[31:0];
                clipx_reg <= clip_reg | s1[32] | s2[32];
                if (AXES < 2)
                begin
                    dy_reg    <= '0;
                    clipo_reg <= clip_reg | s1[32] | s2[32];
                end
            end
            else
            begin
                dy_reg    <= s2[31:0];
                clipo_reg <= clipx_reg | clip_reg | s1[32] | s2[32];
            end
            zo_reg <= (step_reg == 32'd0);
        end
    end

    assign drive_x   = dx_reg;
    assign drive_y   = dy_reg;
    assign clipped   = clipo_reg;
    assign zero_step = zo_reg;

endmodule
`default_nettype wire

>>> design/tapc_control.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapc_control
// sequencer stepping both axes through the datapath operations
// ----------------------------------------------------------------------------
module tapc_control (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire                    out_ready,
    output tapc_pkg::tapc_cmd_t    cmd,
    input  tapc_pkg::tapc_status_t status
);
    import tapc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INC  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_DVI  = 4'd3;
    localparam logic [3:0] S_DVS  = 4'd4;
    localparam logic [3:0] S_DVE  = 4'd5;
    localparam logic [3:0] S_MP   = 4'd6;
    localparam logic [3:0] S_MI   = 4'd7;
    localparam logic [3:0] S_MD   = 4'd8;
    localparam logic [3:0] S_SUM  = 4'd9;
    localparam logic [3:0] S_ERRY = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       axis_reg, axis_next;
    logic       ov_reg, ov_next;

    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        ov_next    = ov_reg && !out_ready;
        cmd.en     = 1'b1;
        cmd.axis   = axis_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.en = in_valid && in_ready;
                cmd.op = OP_LOAD;
                if (in_valid && in_ready)
                begin
                    state_next = S_INC;
                    axis_next  = 1'b0;
                end
            end
            S_ERRY:
            begin
                cmd.op = OP_LOAD; // y error formed from latched copy
                state_next = S_INC;
            end
            S_INC: begin cmd.op = OP_INC;     state_next = S_ACC; end
            S_ACC: begin cmd.op = OP_ACC;     state_next = S_DVI; end
            S_DVI: begin cmd.op = OP_DIVINIT; state_next = S_DVS; end
            S_DVS:
            begin
                cmd.op = OP_DIVSTEP;
                if (status.div_last)
                    state_next = S_DVE;
            end
            S_DVE: begin cmd.op = OP_DIVEND;  state_next = S_MP; end
            S_MP:  begin cmd.op = OP_MULP;    state_next = S_MI; end
            S_MI:  begin cmd.op = OP_MULI;    state_next = S_MD; end
            S_MD:  begin cmd.op = OP_MULD;    state_next = S_SUM; end
            S_SUM:
            begin
                cmd.op = OP_SUM;
                if (axis_reg == 1'b0 && AXES > 1)
                begin
                    axis_next  = 1'b1;
                    state_next = S_ERRY;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = S_IDLE;
                    ov_next    = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_SUM)) else $error("stray result");
    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DVE) |-> $past(status.div_last)) else $error("divider short");
`endif

endmodule
`default_nettype wire

>>> design/two_axis_pid_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_axis_pid_controller_core
// two-axis q16.16 pid controller with saturating arithmetic
// ----------------------------------------------------------------------------
// Each transaction runs both axes in turn through one shared 32x33
// multiplier and a restoring divider that produces one of 48 quotient
// bits per cycle. A new transaction is taken only in the idle state and
// when no result waits or in the cycle the waiting result is taken, so a
// new transaction is never accepted while one is still in progress.
module two_axis_pid_controller_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [31:0] target_x,
    input  wire  [31:0] target_y,
    input  wire  [31:0] measured_x,
    input  wire  [31:0] measured_y,
    input  wire  [31:0] time_step,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [31:0] drive_x,
    output logic [31:0] drive_y,
    output logic        clipped,
    output logic        zero_step
);
    import tapc_pkg::*;

    tapc_cmd_t    cmd;
    tapc_status_t status;

    tapc_control u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
        .cmd, .status
    );

    tapc_datapath u_dp (
        .clk, .rst_n, .cmd, .status, .cfg_we, .cfg_index, .cfg_data,
        .target_x, .target_y, .measured_x, .measured_y, .time_step,
        .drive_x, .drive_y, .clipped, .zero_step
    );

endmodule
`default_nettype wire
